// File: hdl/icaf_pkg.sv
// Package for the attitude filter: payload types, constants, step tables.
package icaf_pkg;

   localparam int ANGLE_WIDTH  = 32;
   localparam int CORDIC_STEPS = 16;
   localparam int STEP_BITS    = 5;
   localparam int QUEUE_DEPTH  = 2;
   localparam int TILT_LIMIT   = 5898240;
   localparam int WEIGHT_RESET = 64225;

   // Register indexes on the configuration port.
   localparam logic [3:0] REG_OFFSET_X = 4'h0;
   localparam logic [3:0] REG_OFFSET_Y = 4'h4;
   localparam logic [3:0] REG_OFFSET_Z = 4'h8;
   localparam logic [3:0] REG_WEIGHT   = 4'hC;

   typedef struct packed {
      logic signed [15:0] accel_x;
      logic signed [15:0] accel_y;
      logic signed [15:0] accel_z;
      logic signed [15:0] temp_raw;
      logic signed [15:0] gyro_x;
      logic signed [15:0] gyro_y;
      logic signed [15:0] gyro_z;
      logic [23:0]        elapsed_us;
   } req_type;

   typedef struct packed {
      logic signed [31:0] roll_angle;
      logic signed [31:0] pitch_angle;
      logic signed [31:0] yaw_angle;
      logic signed [31:0] gyro_angle_x;
      logic signed [31:0] gyro_angle_y;
      logic signed [31:0] gyro_angle_z;
      logic signed [23:0] tilt_x;
      logic signed [23:0] tilt_y;
      logic signed [14:0] temperature;
   } rsp_type;

   // Work item handed from the front part to the back part.
   typedef struct packed {
      logic signed [16:0] delta_x;
      logic signed [16:0] delta_y;
      logic signed [16:0] delta_z;
      logic [32:0]        sq_roll;
      logic [32:0]        sq_pitch;
      logic signed [15:0] accel_x;
      logic signed [15:0] accel_y;
      logic [23:0]        elapsed_us;
      logic signed [14:0] temperature;
   } work_type;

   function automatic logic signed [23:0] atan_entry(input logic [STEP_BITS-1:0] idx);
      logic signed [23:0] v;
      case (idx)
         5'd0:  v = 24'sd2949120;
         5'd1:  v = 24'sd1740967;
         5'd2:  v = 24'sd919879;
         5'd3:  v = 24'sd466945;
         5'd4:  v = 24'sd234379;
         5'd5:  v = 24'sd117304;
         5'd6:  v = 24'sd58666;
         5'd7:  v = 24'sd29335;
         5'd8:  v = 24'sd14668;
         5'd9:  v = 24'sd7334;
         5'd10: v = 24'sd3667;
         5'd11: v = 24'sd1833;
         5'd12: v = 24'sd917;
         5'd13: v = 24'sd458;
         5'd14: v = 24'sd229;
         5'd15: v = 24'sd115;
         5'd16: v = 24'sd57;
         5'd17: v = 24'sd29;
         5'd18: v = 24'sd14;
         5'd19: v = 24'sd7;
         5'd20: v = 24'sd4;
         5'd21: v = 24'sd2;
         5'd22: v = 24'sd1;
         default: v = 24'sd0;
      endcase
      return v;
   endfunction

endpackage

// File: hdl/icaf_front.sv
// Front part: offset removal, sums of squares and temperature conversion.
module icaf_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  icaf_pkg::req_type   req_data,
   input  logic signed [15:0]  offset_x,
   input  logic signed [15:0]  offset_y,
   input  logic signed [15:0]  offset_z,
   output logic                work_valid,
   input  logic                work_ready,
   output icaf_pkg::work_type  work_data
);

   logic                valid_ff, valid_in;
   icaf_pkg::work_type  data_ff, data_in;
   logic signed [31:0]  sq_x, sq_y, sq_z;
   logic signed [18:0]  tnum;
   logic [18:0]         tmag;
   logic [18:0]         tsum;
   logic [38:0]         tprod;
   logic [14:0]         tq;

   assign req_ready  = !valid_ff || work_ready;
   assign work_valid = valid_ff;
   assign work_data  = data_ff;

   always_comb begin
      sq_x = 32'(req_data.accel_x * req_data.accel_x);
      sq_y = 32'(req_data.accel_y * req_data.accel_y);
      sq_z = 32'(req_data.accel_z * req_data.accel_z);
      // (raw + 12412) * 5 / 17, rounded half away from zero.
      tnum = 19'((20'(req_data.temp_raw) + 20'sd12412) * 20'sd5);
      tmag = tnum[18] ? 19'(-tnum) : tnum;
      tsum = tmag + 19'd8;
      // Division by 17 as a multiply by ceil(2^24 / 17); exact for these magnitudes.
      tprod = {20'd0, tsum} * 39'd986896;
      tq   = tprod[38:24];
      data_in             = data_ff;
      data_in.delta_x     = 17'(req_data.gyro_x) - 17'(offset_x);
      data_in.delta_y     = 17'(req_data.gyro_y) - 17'(offset_y);
      data_in.delta_z     = 17'(req_data.gyro_z) - 17'(offset_z);
      data_in.sq_roll     = {1'b0, sq_z} + {1'b0, sq_x};
      data_in.sq_pitch    = {1'b0, sq_z} + {1'b0, sq_y};
      data_in.accel_x     = req_data.accel_x;
      data_in.accel_y     = req_data.accel_y;
      data_in.elapsed_us  = req_data.elapsed_us;
      data_in.temperature = tnum[18] ? 15'(-tq) : tq;
      valid_in = valid_ff;
      if (work_ready) valid_in = 1'b0;
      if (req_valid && req_ready) valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else valid_ff <= valid_in;
      if (req_valid && req_ready) data_ff <= data_in;
   end

endmodule

// File: hdl/icaf_queue.sv
// Short request queue between the front and back parts.
module icaf_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  icaf_pkg::work_type in_data,
   output logic               out_valid,
   input  logic               out_ready,
   output icaf_pkg::work_type out_data
);

   icaf_pkg::work_type entry_ff [icaf_pkg::QUEUE_DEPTH];
   logic [$clog2(icaf_pkg::QUEUE_DEPTH)-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [$clog2(icaf_pkg::QUEUE_DEPTH):0]   count_ff, count_in;
   logic push, pop;

   assign in_ready  = count_ff != ($clog2(icaf_pkg::QUEUE_DEPTH)+1)'(icaf_pkg::QUEUE_DEPTH);
   assign out_valid = count_ff != '0;
   assign out_data  = entry_ff[rd_ff];
   assign push = in_valid && in_ready;
   assign pop  = out_valid && out_ready;

   always_comb begin
      wr_in    = push ? wr_ff + 1'b1 : wr_ff;
      rd_in    = pop ? rd_ff + 1'b1 : rd_ff;
      count_in = count_ff + {{$clog2(icaf_pkg::QUEUE_DEPTH){1'b0}}, push}
                 - {{$clog2(icaf_pkg::QUEUE_DEPTH){1'b0}}, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ff <= wr_in;
         rd_ff <= rd_in;
         count_ff <= count_in;
      end
      if (push) entry_ff[wr_ff] <= in_data;
   end

endmodule

// File: hdl/icaf_back.sv
// Back part: square roots, shared CORDIC, rate division and state update.
module icaf_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               work_valid,
   output logic               work_ready,
   input  icaf_pkg::work_type work_data,
   input  logic [15:0]        weight,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output icaf_pkg::rsp_type  rsp_data
);

   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_SQRT  = 4'd1;
   localparam logic [3:0] ST_CINIT = 4'd2;
   localparam logic [3:0] ST_CORD  = 4'd3;
   localparam logic [3:0] ST_CDONE = 4'd4;
   localparam logic [3:0] ST_MUL   = 4'd5;
   localparam logic [3:0] ST_DIV   = 4'd6;
   localparam logic [3:0] ST_DDONE = 4'd7;
   localparam logic [3:0] ST_BLEND = 4'd8;
   localparam logic [3:0] ST_OUT   = 4'd9;
   localparam int AW = icaf_pkg::ANGLE_WIDTH;
   // The rate divisor 65500000 is 32 * 2046875; the factor 32 is taken out first.
   localparam logic [63:0] RATE_DEN = 64'd2046875;
   localparam logic [63:0] RATE_HALF = 64'd1023437;
   // floor(2^53 / 2046875)
   localparam logic [32:0] RATE_RECIP = 33'd4400463758;

   logic [3:0]  state_ff, state_in;
   icaf_pkg::work_type w_ff;
   logic        axis_ff, axis_in;         // 0: roll tilt, 1: pitch tilt
   logic [1:0]  lane_ff, lane_in;         // gyro axis for the divider
   logic [5:0]  cnt_ff, cnt_in;
   // Square root over (sum << 16), padded to 50 bits, one result bit a cycle.
   logic [49:0] rem_ff, rem_in;
   logic [49:0] rad_ff, rad_in;
   logic [24:0] root_ff, root_in;
   logic [51:0] trial;
   // CORDIC registers.
   logic signed [27:0] cx_ff, cx_in, cy_ff, cy_in;
   logic signed [25:0] cz_ff, cz_in;
   logic signed [23:0] tilt_x_ff, tilt_y_ff, tilt_in;
   // Rate division by reciprocal multiplication and one correction step.
   logic [63:0] num_ff, num_in, q_ff, q_in;
   logic [64:0] drem_ff, drem_in, prod;
   logic signed [63:0] inc_ff [3];
   logic signed [63:0] inc_in;
   // State.
   logic signed [AW-1:0] roll_ff, pitch_ff, yaw_ff, gx_ff, gy_ff, gz_ff;
   logic signed [AW-1:0] roll_in, pitch_in, yaw_in, gx_in, gy_in, gz_in;
   logic signed [AW-1:0] tr, tp;
   logic signed [AW+17:0] sr, sp;
   logic signed [80:0] sy;
   logic signed [16:0] dsel;
   logic [16:0] dmag;
   logic [4:0]  stp;

   assign work_ready = state_ff == ST_IDLE;
   assign rsp_valid  = state_ff == ST_OUT;
   assign stp = cnt_ff[4:0];

   always_comb begin
      rsp_data.roll_angle   = 32'(roll_ff);
      rsp_data.pitch_angle  = 32'(pitch_ff);
      rsp_data.yaw_angle    = 32'(yaw_ff);
      rsp_data.gyro_angle_x = 32'(gx_ff);
      rsp_data.gyro_angle_y = 32'(gy_ff);
      rsp_data.gyro_angle_z = 32'(gz_ff);
      rsp_data.tilt_x       = tilt_x_ff;
      rsp_data.tilt_y       = tilt_y_ff;
      rsp_data.temperature  = w_ff.temperature;
   end

   always_comb begin
      state_in = state_ff; axis_in = axis_ff; lane_in = lane_ff; cnt_in = cnt_ff;
      rem_in = rem_ff; rad_in = rad_ff; root_in = root_ff;
      cx_in = cx_ff; cy_in = cy_ff; cz_in = cz_ff; tilt_in = '0;
      num_in = num_ff; q_in = q_ff; drem_in = drem_ff; inc_in = '0;
      roll_in = roll_ff; pitch_in = pitch_ff; yaw_in = yaw_ff;
      gx_in = gx_ff; gy_in = gy_ff; gz_in = gz_ff;
      trial = '0; prod = '0; tr = '0; tp = '0; sr = '0; sp = '0; sy = '0;
      dsel = (lane_ff == 2'd0) ? w_ff.delta_x :
             (lane_ff == 2'd1) ? w_ff.delta_y : w_ff.delta_z;
      dmag = dsel[16] ? 17'(-dsel) : dsel;
      case (state_ff)
         ST_IDLE: begin
            if (work_valid) begin
               axis_in = 1'b0; state_in = ST_SQRT;
               rem_in = '0; root_in = '0; cnt_in = '0;
               rad_in = {1'b0, work_data.sq_roll, 16'd0};
            end
         end
         ST_SQRT: begin
            // Bring down two radicand bits, try root*4+1.
            trial = {rem_ff, rad_ff[49:48]} - {25'd0, root_ff, 2'b01};
            rad_in = {rad_ff[47:0], 2'b00};
            if (!trial[51]) begin
               rem_in = trial[49:0]; root_in = {root_ff[23:0], 1'b1};
            end else begin
               rem_in = {rem_ff[47:0], rad_ff[49:48]}; root_in = {root_ff[23:0], 1'b0};
            end
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'd24) state_in = ST_CINIT;
         end
         ST_CINIT: begin
            cx_in = 28'(root_ff);
            cy_in = axis_ff ? 28'(w_ff.accel_x) <<< 8 : 28'(w_ff.accel_y) <<< 8;
            cz_in = '0; cnt_in = '0; state_in = ST_CORD;
         end
         ST_CORD: begin
            if (cy_ff >= 0) begin
               cx_in = cx_ff + (cy_ff >>> stp); cy_in = cy_ff - (cx_ff >>> stp);
               cz_in = cz_ff + 26'(icaf_pkg::atan_entry(stp));
            end else begin
               cx_in = cx_ff - (cy_ff >>> stp); cy_in = cy_ff + (cx_ff >>> stp);
               cz_in = cz_ff - 26'(icaf_pkg::atan_entry(stp));
            end
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'(icaf_pkg::CORDIC_STEPS - 1)) state_in = ST_CDONE;
         end
         ST_CDONE: begin
            if (cz_ff > 26'sd5898240) tilt_in = 24'sd5898240;
            else if (cz_ff < -26'sd5898240) tilt_in = -24'sd5898240;
            else tilt_in = 24'(cz_ff);
            // A zero vector stays zero through every step and has no angle.
            if (cx_ff == '0 && cy_ff == '0) tilt_in = '0;
            if (axis_ff) tilt_in = -tilt_in;
            if (!axis_ff) begin
               axis_in = 1'b1; state_in = ST_SQRT;
               rad_in = {1'b0, w_ff.sq_pitch, 16'd0}; rem_in = '0; root_in = '0;
               cnt_in = '0;
            end else begin
               lane_in = 2'd0; state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            num_in = {23'd0, dmag} * {40'd0, w_ff.elapsed_us};
            num_in = (num_in << 11) + RATE_HALF;
            drem_in = '0; q_in = '0; cnt_in = '0; state_in = ST_DIV;
         end
         ST_DIV: begin
            // The estimate is at most one below the quotient; the last cycle corrects it.
            case (cnt_ff[2:0])
               3'd0: begin
                  prod = {33'd0, num_ff[31:0]} * {32'd0, RATE_RECIP};
                  drem_in = prod >> 32;
               end
               3'd1: begin
                  prod = {45'd0, num_ff[51:32]} * {32'd0, RATE_RECIP};
                  drem_in = drem_ff + prod;
               end
               3'd2: q_in = {32'd0, drem_ff[52:21]};
               3'd3: begin
                  prod = {33'd0, q_ff[31:0]} * {1'b0, RATE_DEN};
                  drem_in = {1'b0, num_ff} - prod;
               end
               default: begin
                  if (drem_ff >= {1'b0, RATE_DEN}) q_in = q_ff + 64'd1;
                  state_in = ST_DDONE;
               end
            endcase
            cnt_in = cnt_ff + 6'd1;
         end
         ST_DDONE: begin
            inc_in = dsel[16] ? -$signed(q_ff) : $signed(q_ff);
            if (lane_ff == 2'd2) state_in = ST_BLEND;
            else begin lane_in = lane_ff + 2'd1; state_in = ST_MUL; end
         end
         ST_BLEND: begin
            gx_in = gx_ff + AW'(inc_ff[0]);
            gy_in = gy_ff + AW'(inc_ff[1]);
            gz_in = gz_ff + AW'(inc_ff[2]);
            tr = roll_ff + AW'(inc_ff[0]);
            tp = pitch_ff + AW'(inc_ff[1]);
            sr = $signed({1'b0, weight}) * tr
                 + ($signed(18'sd65536) - $signed({2'b0, weight})) * tilt_x_ff + 32768;
            sp = $signed({1'b0, weight}) * tp
                 + ($signed(18'sd65536) - $signed({2'b0, weight})) * tilt_y_ff + 32768;
            sy = $signed({1'b0, weight}) * $signed(inc_ff[2][32:0]) + 32768;
            roll_in  = AW'(sr >>> 16);
            pitch_in = AW'(sp >>> 16);
            yaw_in   = yaw_ff + AW'(sy >>> 16);
            state_in = ST_OUT;
         end
         ST_OUT: if (rsp_ready) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         roll_ff <= '0; pitch_ff <= '0; yaw_ff <= '0;
         gx_ff <= '0; gy_ff <= '0; gz_ff <= '0;
      end else begin
         state_ff <= state_in;
         roll_ff <= roll_in; pitch_ff <= pitch_in; yaw_ff <= yaw_in;
         gx_ff <= gx_in; gy_ff <= gy_in; gz_ff <= gz_in;
      end
      if (state_ff == ST_IDLE && work_valid) w_ff <= work_data;
      axis_ff <= axis_in; lane_ff <= lane_in; cnt_ff <= cnt_in;
      rem_ff <= rem_in; rad_ff <= rad_in; root_ff <= root_in;
      cx_ff <= cx_in; cy_ff <= cy_in; cz_ff <= cz_in;
      num_ff <= num_in; q_ff <= q_in; drem_ff <= drem_in;
      if (state_ff == ST_CDONE) begin
         if (axis_ff) tilt_y_ff <= tilt_in;
         else tilt_x_ff <= tilt_in;
      end
      if (state_ff == ST_DDONE) inc_ff[lane_ff] <= inc_in;
   end

endmodule

// File: hdl/imu_complementary_attitude_filter.sv
// Top level of the complementary attitude filter.
//  channel | ports       | direction | content
//  request | req_*       | in        | raw six-axis sample, temperature, elapsed time
//  result  | rsp_*       | out       | filtered angles, gyro integrals, tilts, temperature
//  config  | csr_*       | in/out    | gyro offsets and blend weight
// In the back part a request runs through accepting, then for each tilt a square root,
// CORDIC setup, a 16-step CORDIC run and wrap-up, then three rate steps (one per gyro
// axis), blending and the result.
// The front part and a two-entry queue take further requests while the back part works.
// Reset is synchronous; it clears the angle state and the gyro offsets and sets the weight to its reset value.
// A stalled result holds the back part; the front keeps filling the queue.
module imu_complementary_attitude_filter (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  icaf_pkg::req_type  req_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output icaf_pkg::rsp_type  rsp_data,
   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic [3:0]         csr_paddr,
   input  logic [31:0]        csr_pwdata,
   output logic [31:0]        csr_prdata,
   output logic               csr_pready
);

   logic signed [15:0] off_x_ff, off_y_ff, off_z_ff;
   logic [15:0]        weight_ff;
   logic               fw_valid, fw_ready, bw_valid, bw_ready;
   icaf_pkg::work_type fw_data, bw_data;

   assign csr_pready = 1'b1;

   always_comb begin
      case (csr_paddr)
         icaf_pkg::REG_OFFSET_X: csr_prdata = 32'(off_x_ff);
         icaf_pkg::REG_OFFSET_Y: csr_prdata = 32'(off_y_ff);
         icaf_pkg::REG_OFFSET_Z: csr_prdata = 32'(off_z_ff);
         icaf_pkg::REG_WEIGHT:   csr_prdata = {16'd0, weight_ff};
         default:                csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         off_x_ff <= '0; off_y_ff <= '0; off_z_ff <= '0;
         weight_ff <= 16'(icaf_pkg::WEIGHT_RESET);
      end else if (csr_psel && csr_penable && csr_pwrite) begin
         case (csr_paddr)
            icaf_pkg::REG_OFFSET_X: off_x_ff <= csr_pwdata[15:0];
            icaf_pkg::REG_OFFSET_Y: off_y_ff <= csr_pwdata[15:0];
            icaf_pkg::REG_OFFSET_Z: off_z_ff <= csr_pwdata[15:0];
            icaf_pkg::REG_WEIGHT:   weight_ff <= csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   icaf_front u_front (
      .clock, .reset, .req_valid, .req_ready, .req_data,
      .offset_x(off_x_ff), .offset_y(off_y_ff), .offset_z(off_z_ff),
      .work_valid(fw_valid), .work_ready(fw_ready), .work_data(fw_data)
   );

   icaf_queue u_queue (
      .clock, .reset,
      .in_valid(fw_valid), .in_ready(fw_ready), .in_data(fw_data),
      .out_valid(bw_valid), .out_ready(bw_ready), .out_data(bw_data)
   );

   icaf_back u_back (
      .clock, .reset,
      .work_valid(bw_valid), .work_ready(bw_ready), .work_data(bw_data),
      .weight(weight_ff), .rsp_valid, .rsp_ready, .rsp_data
   );

endmodule

// File: hdl/icaf_checker.sv
// Port-level checker for the attitude filter, bound to the top level.
module icaf_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input icaf_pkg::rsp_type rsp_data,
   input logic              csr_pready
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   a_tilt_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.tilt_x <= 24'sd5898240 && rsp_data.tilt_x >= -24'sd5898240)
      else $error("roll tilt outside ninety degrees");

   a_no_rsp_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result shown right after reset");

   a_ready_after_reset: assert property (@(posedge clock)
      reset |=> req_ready)
      else $error("request side not ready right after reset");

   a_pready: assert property (@(posedge clock) csr_pready)
      else $error("configuration port stalled");

endmodule

bind imu_complementary_attitude_filter icaf_checker u_icaf_checker (
   .clock, .reset, .req_ready, .rsp_valid, .rsp_ready, .rsp_data, .csr_pready
);
